// ===== src/gif_lzw_decoder_core_assert.svh =====
// assertion macros shared by the gif lzw decoder modules
`ifndef GIF_LZW_DECODER_CORE_ASSERT_SVH
`define GIF_LZW_DECODER_CORE_ASSERT_SVH

// same-cycle implication, checked out of reset
`define GLZW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define GLZW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/glzw_pkg.sv =====
// types, constants and codes for the gif lzw decoder
`default_nettype none
package glzw_pkg;

    localparam int MAX_CODE_BITS = 12;
    localparam int TABLE_DEPTH   = 4096;
    localparam int AW            = $clog2(TABLE_DEPTH);
    localparam int SLOT_W        = AW + 1;
    localparam int CODE_W        = MAX_CODE_BITS;
    localparam int PEND_DEPTH    = 64;
    localparam int PCNT_W        = $clog2(PEND_DEPTH) + 1;
    localparam int ACC_W         = 20;
    localparam int HELD_W        = 5;
    localparam logic [3:0] ROOT_RESET = 4'd8;
    localparam logic [3:0] ROOT_MIN   = 4'd2;
    localparam logic [3:0] ROOT_MAX   = 4'd9;

    typedef enum logic [1:0] {
        RES_PIXELS  = 2'd0,
        RES_END     = 2'd1,
        RES_INVALID = 2'd2,
        RES_TRUNC   = 2'd3
    } res_status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
        logic       final_byte;
    } in_item_t;

    typedef struct packed {
        logic [63:0] pixels_0;
        logic [63:0] pixels_1;
        logic [63:0] pixels_2;
        logic [63:0] pixels_3;
        logic [63:0] pixels_4;
        logic [63:0] pixels_5;
        logic [63:0] pixels_6;
        logic [63:0] pixels_7;
        logic [6:0]  pixel_count;
        logic [1:0]  status;
        logic        run_last;
    } out_item_t;

    typedef enum logic [4:0] {
        OP_NONE,
        OP_ACCEPT,
        OP_LENGTH,
        OP_SHIFTIN,
        OP_EXTRACT,
        OP_CLEAR,
        OP_END,
        OP_INVALID,
        OP_TRUNC,
        OP_FIRSTCODE,
        OP_PUT_CODE,
        OP_START,
        OP_WALK_RD,
        OP_WALK_PUSH,
        OP_ROOT_PUSH,
        OP_UPDATE,
        OP_POP_RD,
        OP_PUT_STACK,
        OP_EMIT_FULL,
        OP_EMIT_LAST
    } dp_op_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CHECK,
        ST_EXTRACT,
        ST_DECODE,
        ST_PUTAC,
        ST_WALK,
        ST_WALK2,
        ST_UPDATE,
        ST_POP,
        ST_POP2,
        ST_TAIL,
        ST_FLUSH
    } ctrl_state_t;

    typedef struct packed {
        dp_op_t op;
    } dp_cmd_t;

    typedef struct packed {
        logic finished;
        logic left_zero;
        logic status_set;
        logic have_code;
        logic is_end;
        logic is_clear;
        logic after_clear;
        logic above_next;
        logic code_ge_base;
        logic sp_zero;
        logic pend_full;
        logic pend_some;
        logic out_free;
        logic last;
    } dp_stat_t;

endpackage
`default_nettype wire

// ===== src/gif_lzw_decoder_core.sv =====
// a data byte is accepted, checked and shifted in; each code is then extracted, decoded,
// walked through the prefix/suffix table one chain entry at a time and popped from the
// reversal stack one pixel at a time, which sets the rate; one byte is taken at a time
// results leave through an output register; the next byte is taken while it waits
// reset: synchronous active-low aresetn, root size 8, no table clearing pass
`default_nettype none
module gif_lzw_decoder_core (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [3:0]          cfg_wdata,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire glzw_pkg::in_item_t  s_data,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output glzw_pkg::out_item_t      m_data
);

    glzw_pkg::dp_cmd_t  cmd;
    glzw_pkg::dp_stat_t stat;

    glzw_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    glzw_dp u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_data    (s_data),
        .cmd       (cmd),
        .stat      (stat),
        .m_data    (m_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready)
    );

endmodule
`default_nettype wire

// ===== src/glzw_ctrl.sv =====
// sequencer for byte intake, code decode, chain walk and result emission
`default_nettype none
`include "gif_lzw_decoder_core_assert.svh"
module glzw_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire glzw_pkg::dp_stat_t stat,
    output glzw_pkg::dp_cmd_t      cmd
);

    glzw_pkg::ctrl_state_t state_reg, state_next;
    glzw_pkg::ctrl_state_t ret_reg, ret_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= glzw_pkg::ST_IDLE;
            ret_reg   <= glzw_pkg::ST_IDLE;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        cmd.op     = glzw_pkg::OP_NONE;
        s_ready    = 1'b0;
        case (state_reg)
            glzw_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = glzw_pkg::OP_ACCEPT;
                    state_next = glzw_pkg::ST_CHECK;
                end
            end
            glzw_pkg::ST_CHECK: begin
                if (stat.finished) begin
                    state_next = glzw_pkg::ST_IDLE;
                end else if (stat.left_zero) begin
                    cmd.op     = glzw_pkg::OP_LENGTH;
                    state_next = glzw_pkg::ST_TAIL;
                end else begin
                    cmd.op     = glzw_pkg::OP_SHIFTIN;
                    state_next = glzw_pkg::ST_EXTRACT;
                end
            end
            glzw_pkg::ST_EXTRACT: begin
                if (stat.have_code) begin
                    cmd.op     = glzw_pkg::OP_EXTRACT;
                    state_next = glzw_pkg::ST_DECODE;
                end else begin
                    state_next = glzw_pkg::ST_TAIL;
                end
            end
            glzw_pkg::ST_DECODE: begin
                if (stat.is_end) begin
                    cmd.op     = glzw_pkg::OP_END;
                    state_next = glzw_pkg::ST_TAIL;
                end else if (stat.is_clear) begin
                    cmd.op     = glzw_pkg::OP_CLEAR;
                    state_next = glzw_pkg::ST_EXTRACT;
                end else if (stat.after_clear) begin
                    cmd.op     = glzw_pkg::OP_FIRSTCODE;
                    state_next = glzw_pkg::ST_PUTAC;
                end else if (stat.above_next) begin
                    cmd.op     = glzw_pkg::OP_INVALID;
                    state_next = glzw_pkg::ST_TAIL;
                end else begin
                    cmd.op     = glzw_pkg::OP_START;
                    state_next = glzw_pkg::ST_WALK;
                end
            end
            glzw_pkg::ST_PUTAC: begin
                if (stat.pend_full) begin
                    ret_next   = glzw_pkg::ST_PUTAC;
                    state_next = glzw_pkg::ST_FLUSH;
                end else begin
                    cmd.op     = glzw_pkg::OP_PUT_CODE;
                    state_next = glzw_pkg::ST_EXTRACT;
                end
            end
            glzw_pkg::ST_WALK: begin
                if (stat.code_ge_base) begin
                    cmd.op     = glzw_pkg::OP_WALK_RD;
                    state_next = glzw_pkg::ST_WALK2;
                end else begin
                    cmd.op     = glzw_pkg::OP_ROOT_PUSH;
                    state_next = glzw_pkg::ST_UPDATE;
                end
            end
            glzw_pkg::ST_WALK2: begin
                cmd.op     = glzw_pkg::OP_WALK_PUSH;
                state_next = glzw_pkg::ST_WALK;
            end
            glzw_pkg::ST_UPDATE: begin
                cmd.op     = glzw_pkg::OP_UPDATE;
                state_next = glzw_pkg::ST_POP;
            end
            glzw_pkg::ST_POP: begin
                if (stat.sp_zero) begin
                    state_next = glzw_pkg::ST_EXTRACT;
                end else begin
                    cmd.op     = glzw_pkg::OP_POP_RD;
                    state_next = glzw_pkg::ST_POP2;
                end
            end
            glzw_pkg::ST_POP2: begin
                if (stat.pend_full) begin
                    ret_next   = glzw_pkg::ST_POP2;
                    state_next = glzw_pkg::ST_FLUSH;
                end else begin
                    cmd.op     = glzw_pkg::OP_PUT_STACK;
                    state_next = glzw_pkg::ST_POP;
                end
            end
            glzw_pkg::ST_TAIL: begin
                if (!stat.status_set && stat.last) begin
                    cmd.op = glzw_pkg::OP_TRUNC;
                end else if (stat.status_set && stat.pend_full) begin
                    // a full buffer goes out ahead of the status transaction
                    ret_next   = glzw_pkg::ST_TAIL;
                    state_next = glzw_pkg::ST_FLUSH;
                end else if (stat.status_set || stat.pend_some) begin
                    if (stat.out_free) begin
                        cmd.op     = glzw_pkg::OP_EMIT_LAST;
                        state_next = glzw_pkg::ST_IDLE;
                    end
                end else begin
                    state_next = glzw_pkg::ST_IDLE;
                end
            end
            glzw_pkg::ST_FLUSH: begin
                if (stat.out_free) begin
                    cmd.op     = glzw_pkg::OP_EMIT_FULL;
                    state_next = ret_reg;
                end
            end
            default: begin
                state_next = glzw_pkg::ST_IDLE;
            end
        endcase
    end

    `GLZW_ASSERT_NEXT(a_accept_to_check, (state_reg == glzw_pkg::ST_IDLE && s_valid),
        (state_reg == glzw_pkg::ST_CHECK), "accepted byte did not start processing")
    `GLZW_ASSERT_NEXT(a_flush_returns, (state_reg == glzw_pkg::ST_FLUSH && stat.out_free),
        (state_reg == $past(ret_reg)), "flush did not return to its caller")
    `GLZW_ASSERT_NOW(a_flush_caller, (state_reg == glzw_pkg::ST_FLUSH),
        (ret_reg == glzw_pkg::ST_PUTAC || ret_reg == glzw_pkg::ST_POP2
         || ret_reg == glzw_pkg::ST_TAIL), "flush with bad return state")

endmodule
`default_nettype wire

// ===== src/glzw_dp.sv =====
// bit unpacking, code tables, reversal stack, pixel packing and output register
`default_nettype none
`include "gif_lzw_decoder_core_assert.svh"
module glzw_dp (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                cfg_we,
    input  wire logic [3:0]          cfg_wdata,
    input  wire glzw_pkg::in_item_t  s_data,
    input  wire glzw_pkg::dp_cmd_t   cmd,
    output glzw_pkg::dp_stat_t       stat,
    output glzw_pkg::out_item_t      m_data,
    output logic                     m_valid,
    input  wire logic                m_ready
);

    localparam int AW     = glzw_pkg::AW;
    localparam int SW     = glzw_pkg::SLOT_W;
    localparam int CW     = glzw_pkg::CODE_W;
    localparam int PD     = glzw_pkg::PEND_DEPTH;
    localparam int PCW    = glzw_pkg::PCNT_W;
    localparam int ACW    = glzw_pkg::ACC_W;
    localparam int HW     = glzw_pkg::HELD_W;

    logic [3:0]     root_reg;
    logic [3:0]     act_root_reg;
    logic [3:0]     cw_reg;
    logic [SW-1:0]  next_reg;
    logic [SW-1:0]  limit_reg;
    logic [CW-1:0]  prev_reg;
    logic [7:0]     first_reg;
    logic [ACW-1:0] acc_reg;
    logic [HW-1:0]  held_reg;
    logic [7:0]     left_reg;
    logic           ac_reg;
    logic           fin_reg;
    logic [7:0]     byte_reg;
    logic           last_reg;
    logic [1:0]     st_reg;
    logic [CW-1:0]  c_reg;
    logic [CW-1:0]  code_reg;
    logic [SW-1:0]  sp_reg;
    logic [PCW-1:0] pcnt_reg;
    logic           ovalid_reg;
    glzw_pkg::out_item_t out_reg;
    logic [7:0]     pend_reg [PD];

    logic [CW-1:0]  prefix_mem [glzw_pkg::TABLE_DEPTH];
    logic [7:0]     suffix_mem [glzw_pkg::TABLE_DEPTH];
    logic [7:0]     stack_mem  [glzw_pkg::TABLE_DEPTH];
    logic [CW-1:0]  pre_q_reg;
    logic [7:0]     suf_q_reg;
    logic [7:0]     stk_q_reg;

    logic [3:0]     r_clamp;
    logic [SW-1:0]  clear_code;
    logic [SW-1:0]  base_code;
    logic [SW-1:0]  code_mask;
    logic [SW-1:0]  c_ext;
    logic           kwkwk;
    logic           slot_free;
    logic [SW-1:0]  next_upd;
    logic           push_en;
    logic [7:0]     push_val;
    logic           put_en;
    logic [7:0]     put_val;
    logic           emit_en;
    logic           out_free;
    logic [SW-1:0]  sp_m1;
    logic [PD*8-1:0] pend_flat;

    always_comb begin
        if (root_reg < glzw_pkg::ROOT_MIN) begin
            r_clamp = glzw_pkg::ROOT_MIN;
        end else if (root_reg > glzw_pkg::ROOT_MAX) begin
            r_clamp = glzw_pkg::ROOT_MAX;
        end else begin
            r_clamp = root_reg;
        end
    end

    assign clear_code = SW'(1) << act_root_reg;
    assign base_code  = clear_code + SW'(2);
    assign code_mask  = (SW'(1) << cw_reg) - SW'(1);
    assign c_ext      = {{(SW-CW){1'b0}}, c_reg};
    assign kwkwk      = (c_ext == next_reg);
    assign slot_free  = (next_reg < limit_reg);
    assign next_upd   = slot_free ? next_reg + SW'(1) : next_reg;
    assign sp_m1      = sp_reg - SW'(1);
    assign out_free   = !ovalid_reg || m_ready;
    assign emit_en    = (cmd.op == glzw_pkg::OP_EMIT_FULL) || (cmd.op == glzw_pkg::OP_EMIT_LAST);

    always_comb begin
        push_en  = 1'b0;
        push_val = 8'd0;
        case (cmd.op)
            glzw_pkg::OP_START: begin
                push_en  = kwkwk;
                push_val = first_reg;
            end
            glzw_pkg::OP_WALK_PUSH: begin
                push_en  = 1'b1;
                push_val = suf_q_reg;
            end
            glzw_pkg::OP_ROOT_PUSH: begin
                push_en  = 1'b1;
                push_val = code_reg[7:0];
            end
            default: begin
                push_en  = 1'b0;
            end
        endcase
    end

    assign put_en  = (cmd.op == glzw_pkg::OP_PUT_CODE) || (cmd.op == glzw_pkg::OP_PUT_STACK);
    assign put_val = (cmd.op == glzw_pkg::OP_PUT_CODE) ? code_reg[7:0] : stk_q_reg;

    always_comb begin
        for (int i = 0; i < PD; i++) begin
            pend_flat[i*8 +: 8] = pend_reg[i];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            root_reg     <= glzw_pkg::ROOT_RESET;
            act_root_reg <= glzw_pkg::ROOT_RESET;
            cw_reg       <= glzw_pkg::ROOT_RESET + 4'd1;
            limit_reg    <= SW'(1) << (glzw_pkg::ROOT_RESET + 4'd1);
            next_reg     <= (SW'(1) << glzw_pkg::ROOT_RESET) + SW'(2);
            prev_reg     <= '0;
            first_reg    <= '0;
            acc_reg      <= '0;
            held_reg     <= '0;
            left_reg     <= '0;
            ac_reg       <= 1'b0;
            fin_reg      <= 1'b0;
            st_reg       <= glzw_pkg::RES_PIXELS;
            last_reg     <= 1'b0;
            sp_reg       <= '0;
            pcnt_reg     <= '0;
            ovalid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                root_reg <= cfg_wdata;
            end
            if (m_ready && !emit_en) begin
                ovalid_reg <= 1'b0;
            end
            if (push_en && !sp_reg[SW-1]) begin
                sp_reg <= sp_reg + SW'(1);
            end
            if (put_en) begin
                pcnt_reg <= pcnt_reg + PCW'(1);
            end
            case (cmd.op)
                glzw_pkg::OP_ACCEPT: begin
                    last_reg <= s_data.final_byte;
                    st_reg   <= glzw_pkg::RES_PIXELS;
                    sp_reg   <= '0;
                    pcnt_reg <= '0;
                    if (s_data.first_byte) begin
                        act_root_reg <= r_clamp;
                        cw_reg       <= r_clamp + 4'd1;
                        limit_reg    <= SW'(1) << (r_clamp + 4'd1);
                        next_reg     <= (SW'(1) << r_clamp) + SW'(2);
                        prev_reg     <= '0;
                        first_reg    <= '0;
                        acc_reg      <= '0;
                        held_reg     <= '0;
                        left_reg     <= '0;
                        ac_reg       <= 1'b0;
                        fin_reg      <= 1'b0;
                    end
                end
                glzw_pkg::OP_LENGTH: begin
                    if (byte_reg == 8'd0) begin
                        st_reg <= glzw_pkg::RES_TRUNC;
                    end else begin
                        left_reg <= byte_reg;
                    end
                end
                glzw_pkg::OP_SHIFTIN: begin
                    left_reg <= left_reg - 8'd1;
                    acc_reg  <= acc_reg | (ACW'(byte_reg) << held_reg);
                    held_reg <= held_reg + HW'(8);
                end
                glzw_pkg::OP_EXTRACT: begin
                    c_reg    <= acc_reg[CW-1:0] & code_mask[CW-1:0];
                    acc_reg  <= acc_reg >> cw_reg;
                    held_reg <= held_reg - HW'(cw_reg);
                end
                glzw_pkg::OP_CLEAR: begin
                    cw_reg    <= act_root_reg + 4'd1;
                    next_reg  <= base_code;
                    limit_reg <= SW'(1) << (act_root_reg + 4'd1);
                    ac_reg    <= 1'b1;
                end
                glzw_pkg::OP_END: begin
                    st_reg <= glzw_pkg::RES_END;
                end
                glzw_pkg::OP_INVALID: begin
                    st_reg <= glzw_pkg::RES_INVALID;
                end
                glzw_pkg::OP_TRUNC: begin
                    st_reg <= glzw_pkg::RES_TRUNC;
                end
                glzw_pkg::OP_FIRSTCODE: begin
                    ac_reg <= 1'b0;
                    // first code after clear at or past the free slot reads as zero
                    if (c_ext >= next_reg) begin
                        code_reg  <= '0;
                        prev_reg  <= '0;
                        first_reg <= '0;
                    end else begin
                        code_reg  <= c_reg;
                        prev_reg  <= c_reg;
                        first_reg <= c_reg[7:0];
                    end
                end
                glzw_pkg::OP_START: begin
                    code_reg <= kwkwk ? prev_reg : c_reg;
                end
                glzw_pkg::OP_WALK_PUSH: begin
                    code_reg <= pre_q_reg;
                end
                glzw_pkg::OP_UPDATE: begin
                    // full table: no new entry and previous code stays stale
                    if (slot_free) begin
                        first_reg <= code_reg[7:0];
                        next_reg  <= next_upd;
                        prev_reg  <= c_reg;
                    end
                    if (next_upd >= limit_reg && cw_reg < 4'(glzw_pkg::MAX_CODE_BITS)) begin
                        limit_reg <= limit_reg << 1;
                        cw_reg    <= cw_reg + 4'd1;
                    end
                end
                glzw_pkg::OP_POP_RD: begin
                    sp_reg <= sp_m1;
                end
                glzw_pkg::OP_EMIT_FULL: begin
                    ovalid_reg <= 1'b1;
                    pcnt_reg   <= '0;
                end
                glzw_pkg::OP_EMIT_LAST: begin
                    ovalid_reg <= 1'b1;
                    pcnt_reg   <= '0;
                    if (st_reg != glzw_pkg::RES_PIXELS) begin
                        fin_reg <= 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (cmd.op == glzw_pkg::OP_ACCEPT) begin
            byte_reg <= s_data.data_byte;
        end
        if (emit_en) begin
            for (int i = 0; i < PD; i++) begin
                pend_reg[i] <= 8'd0;
            end
            out_reg.pixels_0    <= pend_flat[63:0];
            out_reg.pixels_1    <= pend_flat[127:64];
            out_reg.pixels_2    <= pend_flat[191:128];
            out_reg.pixels_3    <= pend_flat[255:192];
            out_reg.pixels_4    <= pend_flat[319:256];
            out_reg.pixels_5    <= pend_flat[383:320];
            out_reg.pixels_6    <= pend_flat[447:384];
            out_reg.pixels_7    <= pend_flat[511:448];
            out_reg.pixel_count <= 7'(pcnt_reg);
            if (cmd.op == glzw_pkg::OP_EMIT_LAST) begin
                out_reg.status   <= st_reg;
                out_reg.run_last <= 1'b1;
            end else begin
                out_reg.status   <= glzw_pkg::RES_PIXELS;
                out_reg.run_last <= 1'b0;
            end
        end else if (cmd.op == glzw_pkg::OP_ACCEPT) begin
            for (int i = 0; i < PD; i++) begin
                pend_reg[i] <= 8'd0;
            end
        end else if (put_en) begin
            pend_reg[pcnt_reg[PCW-2:0]] <= put_val;
        end
    end

    // string tables
    always_ff @(posedge aclk) begin
        if (cmd.op == glzw_pkg::OP_UPDATE && slot_free) begin
            suffix_mem[next_reg[AW-1:0]] <= code_reg[7:0];
            prefix_mem[next_reg[AW-1:0]] <= prev_reg;
        end
        if (cmd.op == glzw_pkg::OP_WALK_RD) begin
            suf_q_reg <= suffix_mem[AW'(code_reg)];
            pre_q_reg <= prefix_mem[AW'(code_reg)];
        end
    end

    // reversal stack
    always_ff @(posedge aclk) begin
        if (push_en && !sp_reg[SW-1]) begin
            stack_mem[sp_reg[AW-1:0]] <= push_val;
        end
        if (cmd.op == glzw_pkg::OP_POP_RD) begin
            stk_q_reg <= stack_mem[sp_m1[AW-1:0]];
        end
    end

    assign stat.finished     = fin_reg;
    assign stat.left_zero    = (left_reg == 8'd0);
    assign stat.status_set   = (st_reg != glzw_pkg::RES_PIXELS);
    assign stat.have_code    = (held_reg >= HW'(cw_reg));
    assign stat.is_end       = (c_ext == clear_code + SW'(1));
    assign stat.is_clear     = (c_ext == clear_code);
    assign stat.after_clear  = ac_reg;
    assign stat.above_next   = (c_ext > next_reg);
    assign stat.code_ge_base = ({{(SW-CW){1'b0}}, code_reg} >= base_code);
    assign stat.sp_zero      = (sp_reg == '0);
    assign stat.pend_full    = pcnt_reg[PCW-1];
    assign stat.pend_some    = (pcnt_reg != '0);
    assign stat.out_free     = out_free;
    assign stat.last         = last_reg;

    assign m_data  = out_reg;
    assign m_valid = ovalid_reg;

    `GLZW_ASSERT_NOW(a_sp_bound, 1'b1, (!sp_reg[SW-1] || sp_reg[AW-1:0] == '0),
        "reversal stack pointer past depth")
    `GLZW_ASSERT_NOW(a_pend_bound, 1'b1, (!pcnt_reg[PCW-1] || pcnt_reg[PCW-2:0] == '0),
        "pixel buffer count past 64")
    `GLZW_ASSERT_NEXT(a_emit_clears, emit_en, (pcnt_reg == '0 && ovalid_reg),
        "emission did not load output and clear buffer")
    `GLZW_ASSERT_NOW(a_width_range, 1'b1,
        (cw_reg >= 4'd3 && cw_reg <= 4'(glzw_pkg::MAX_CODE_BITS)), "code width out of range")

endmodule
`default_nettype wire
